// ===== design/kss_pkg.sv =====
// kss_pkg: shared sizes, op codes, sequencer states and the order functions
// for the k-th smallest select engine. No dependencies.
package kss_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int DATA_W       = 32;
    localparam int RANK_W       = 10;
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W        = IDX_W + 1;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RANGE = 9'b000000010,
        S_PIVOT = 9'b000000100,
        S_J_RD  = 9'b000001000,
        S_J_CMP = 9'b000010000,
        S_I_RD  = 9'b000100000,
        S_I_CMP = 9'b001000000,
        S_PLACE = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // signed order: a greater than b
    function automatic logic key_gt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        key_gt = $signed(a) > $signed(b);
    endfunction

    function automatic logic key_lt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        key_lt = $signed(a) < $signed(b);
    endfunction

endpackage

// ===== design/kss_ram.sv =====
// kss_ram: generic single-clock RAM, one write port and one read port,
// read data registered. No package dependency.
module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/kth_smallest_select_engine_top.sv =====
// kth_smallest_select_engine_top: element store plus quickselect sequencer.
// Depends on kss_pkg and kss_ram.
//
// Usage:
//   Input channel (i_valid/o_ready, fields i_op, i_value, i_rank): an item
//   with op append stores i_value at the end of the set; an item with op
//   select asks for the element of zero-based rank i_rank.
//   Output channel (o_valid/i_ready, fields o_selected, o_rank_error): one
//   item per select, none per append. A rank not below the count, or an
//   append beyond the store depth since the last select, gives
//   o_rank_error = 1 and o_selected = 0. Every select empties the set.
//   Throughput: appends are taken one per cycle while the sequencer is idle.
//   A select occupies the sequencer for its whole search. Each element
//   visited by a partition pass takes a read state and a compare state,
//   since the store has a single read port and registered read data.
//   An error select goes from idle straight to the done state, with no search.
//   Latency: the result item is registered and appears after the search.
//   Stall: the result waits in the output register; the sequencer holds in
//   its done state while a previous result is still not taken, and new
//   appends are accepted only once the sequencer is back to idle.
//   Reset: clears the count, overflow flag, sequencer and output valid.
//   The store itself needs no clearing; only written entries are read.
module kth_smallest_select_engine_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic signed [kss_pkg::DATA_W-1:0]   i_value,
    input  logic [kss_pkg::RANK_W-1:0]          i_rank,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [kss_pkg::DATA_W-1:0]   o_selected,
    output logic                                o_rank_error
);

    localparam int DW = kss_pkg::DATA_W;
    localparam int IW = kss_pkg::IDX_W;
    localparam int CW = kss_pkg::CNT_W;

    kss_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_overflow, n_overflow;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_k, n_k;
    logic [DW-1:0] r_pivot, n_pivot;
    logic [DW-1:0] r_res, n_res;
    logic          r_err, n_err;
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_out_data, n_out_data;
    logic          r_out_err, n_out_err;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          in_acc;
    logic [CW-1:0] cnt_m1;

    kss_ram #(
        .WIDTH (DW),
        .DEPTH (kss_pkg::MAX_ELEMENTS),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_ready      = (r_state == kss_pkg::S_IDLE);
    assign in_acc       = i_valid && o_ready;
    assign cnt_m1       = r_count - CW'(1);
    assign o_valid      = r_out_valid;
    assign o_selected   = r_out_data;
    assign o_rank_error = r_out_err;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_pivot     = r_pivot;
        n_res       = r_res;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        n_out_err   = r_out_err;
        wr_en       = 1'b0;
        wr_addr     = r_i;
        wr_data     = rd_data;
        rd_addr     = r_lo;

        unique case (r_state)
            kss_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_op == kss_pkg::OP_APPEND) begin
                        if (r_count < CW'(kss_pkg::MAX_ELEMENTS)) begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[IW-1:0];
                            wr_data = i_value;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end else begin
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_lo       = '0;
                        n_hi       = cnt_m1[IW-1:0];
                        n_k        = IW'(i_rank);
                        if (r_overflow || (32'(i_rank) >= 32'(r_count))) begin
                            n_res   = '0;
                            n_err   = 1'b1;
                            n_state = kss_pkg::S_DONE;
                        end else begin
                            n_err   = 1'b0;
                            n_state = kss_pkg::S_RANGE;
                        end
                    end
                end
            end
            kss_pkg::S_RANGE: begin
                rd_addr = r_lo;
                n_state = kss_pkg::S_PIVOT;
            end
            kss_pkg::S_PIVOT: begin
                if (r_lo >= r_hi) begin
                    n_res   = rd_data;
                    n_state = kss_pkg::S_DONE;
                end else begin
                    n_pivot = rd_data;
                    n_i     = r_lo;
                    n_j     = r_hi;
                    n_state = kss_pkg::S_J_RD;
                end
            end
            kss_pkg::S_J_RD: begin
                rd_addr = r_j;
                n_state = (r_i < r_j) ? kss_pkg::S_J_CMP : kss_pkg::S_PLACE;
            end
            kss_pkg::S_J_CMP: begin
                if (kss_pkg::key_gt(rd_data, r_pivot)) begin
                    n_j     = r_j - IW'(1);
                    n_state = kss_pkg::S_J_RD;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_i;
                    wr_data = rd_data;
                    n_i     = r_i + IW'(1);
                    n_state = kss_pkg::S_I_RD;
                end
            end
            kss_pkg::S_I_RD: begin
                rd_addr = r_i;
                n_state = (r_i < r_j) ? kss_pkg::S_I_CMP : kss_pkg::S_PLACE;
            end
            kss_pkg::S_I_CMP: begin
                if (kss_pkg::key_lt(rd_data, r_pivot)) begin
                    n_i     = r_i + IW'(1);
                    n_state = kss_pkg::S_I_RD;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_j;
                    wr_data = rd_data;
                    n_j     = r_j - IW'(1);
                    n_state = kss_pkg::S_J_RD;
                end
            end
            kss_pkg::S_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_pivot;
                if (r_i == r_k) begin
                    n_res   = r_pivot;
                    n_state = kss_pkg::S_DONE;
                end else if (r_i < r_k) begin
                    n_lo    = r_i + IW'(1);
                    n_state = kss_pkg::S_RANGE;
                end else begin
                    n_hi    = r_i - IW'(1);
                    n_state = kss_pkg::S_RANGE;
                end
            end
            kss_pkg::S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_out_err   = r_err;
                    n_state     = kss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kss_pkg::S_IDLE;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_pivot    <= n_pivot;
        r_res      <= n_res;
        r_err      <= n_err;
        r_out_data <= n_out_data;
        r_out_err  <= n_out_err;
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_data == '0))
        else $error("error result with nonzero value");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(kss_pkg::MAX_ELEMENTS))
        else $error("element count beyond store depth");

    a_select_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_op == kss_pkg::OP_SELECT)) |=> (r_count == '0 && !r_overflow))
        else $error("set not emptied after select");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == kss_pkg::S_J_CMP) || (r_state == kss_pkg::S_I_CMP)) |-> (r_i < r_j))
        else $error("partition indices crossed during scan");

    a_place_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kss_pkg::S_PLACE) |-> ((r_i >= r_lo) && (r_i <= r_hi) && (r_i == r_j)))
        else $error("pivot placed outside the search range");

endmodule

// ===== sim/kth_smallest_select_engine_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for kth_smallest_select_engine_top: drives append and
// select items, predicts each selected element with its own quickselect and
// checks every result item field by field. Depends on kss_pkg and the RTL.
module kth_smallest_select_engine_top_test;

    localparam int IDLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 625;
    localparam int MIN_SELECTS  = 40;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANK_MAX     = (1 << kss_pkg::RANK_W) - 1;

    typedef logic signed [kss_pkg::DATA_W-1:0] t_word;
    typedef logic [kss_pkg::RANK_W-1:0] t_rank;
    typedef struct packed {
        t_word selected;
        logic  rank_error;
    } t_select_result;
    typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_RISING, FILL_FALLING} t_fill;

    class rank_select_scoreboard;
        t_word          elements [kss_pkg::MAX_ELEMENTS];
        int             loaded;
        bit             overflowed;
        t_select_result awaited_results [$];
        int             errors;

        function new();
            loaded     = 0;
            overflowed = 0;
            errors     = 0;
        endfunction

        function t_word find_rank(int k);
            int    lo, hi, i, j;
            t_word pivot, found;
            bit    done;
            lo    = 0;
            hi    = loaded - 1;
            done  = 0;
            found = '0;
            while (!done) begin
                if (lo >= hi) begin
                    found = elements[lo];
                    done  = 1;
                end else begin
                    i     = lo;
                    j     = hi;
                    pivot = elements[i];
                    while (i < j) begin
                        while (i < j && elements[j] > pivot) j--;
                        if (i < j) begin
                            elements[i] = elements[j];
                            i++;
                        end
                        while (i < j && elements[i] < pivot) i++;
                        if (i < j) begin
                            elements[j] = elements[i];
                            j--;
                        end
                    end
                    elements[i] = pivot;
                    if (i == k) begin
                        found = pivot;
                        done  = 1;
                    end else if (i < k) begin
                        lo = i + 1;
                    end else begin
                        hi = i - 1;
                    end
                end
            end
            return found;
        endfunction

        task report_mismatch(string what);
            if (errors < 50) $display("mismatch: %s", what);
            errors++;
        endtask

        function void note_item(logic op, t_word value, t_rank rank);
            t_select_result r;
            if (op == kss_pkg::OP_APPEND) begin
                if (loaded < kss_pkg::MAX_ELEMENTS) begin
                    elements[loaded] = value;
                    loaded++;
                end else begin
                    overflowed = 1;
                end
            end else begin
                if (overflowed || int'(rank) >= loaded) begin
                    r.selected   = '0;
                    r.rank_error = 1'b1;
                end else begin
                    r.selected   = find_rank(int'(rank));
                    r.rank_error = 1'b0;
                end
                awaited_results.push_back(r);
                loaded     = 0;
                overflowed = 0;
            end
        endfunction

        task check_item(t_word selected, logic rank_error);
            t_select_result r;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result selected %0d rank_error %0b",
                                          selected, rank_error));
            end else begin
                r = awaited_results.pop_front();
                if (selected !== r.selected)
                    report_mismatch($sformatf("selected %0d, predicted %0d",
                                              selected, r.selected));
                if (rank_error !== r.rank_error)
                    report_mismatch($sformatf("rank_error %0b, predicted %0b",
                                              rank_error, r.rank_error));
            end
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic                             i_op;
    logic signed [kss_pkg::DATA_W-1:0] i_value;
    logic [kss_pkg::RANK_W-1:0]       i_rank;
    logic                             o_valid;
    logic                             i_ready;
    logic signed [kss_pkg::DATA_W-1:0] o_selected;
    logic                             o_rank_error;

    rank_select_scoreboard sb = new();
    int burst_left   = 0;
    int selects_sent = 0;
    int idle_cycles  = 0;
    bit hold_req     = 0;

    kth_smallest_select_engine_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_rank       (i_rank),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_selected   (o_selected),
        .o_rank_error (o_rank_error)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_item(o_selected, o_rank_error);
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial begin
        int ready_pct, left;
        bit held;
        i_ready   = 1'b0;
        ready_pct = 100;
        left      = 0;
        held      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1;
            end
            if (left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 50;
                    default: ready_pct = 20;
                endcase
                left = $urandom_range(8, 96);
            end
            left--;
            i_ready = ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic send_item(logic op, t_word value, t_rank rank);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_valid = 1'b1;
        i_op    = op;
        i_value = value;
        i_rank  = rank;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(op, value, rank);
        if (op == kss_pkg::OP_SELECT) selects_sent++;
        @(negedge i_clk);
    endtask

    task automatic append_set(int n, t_fill fill);
        t_word base, v;
        base = t_word'($urandom_range(0, 2000)) - 1000;
        for (int idx = 0; idx < n; idx++) begin
            case (fill)
                FILL_RANDOM: v = $urandom;
                FILL_NARROW: v = t_word'($urandom_range(0, 3)) - 2;
                FILL_RISING: v = base + idx * 3;
                default:     v = base - idx * 3;
            endcase
            send_item(kss_pkg::OP_APPEND, v, t_rank'($urandom_range(0, RANK_MAX)));
        end
    endtask

    task automatic request_rank(int rank);
        send_item(kss_pkg::OP_SELECT, $urandom, rank[kss_pkg::RANK_W-1:0]);
    endtask

    initial begin
        t_word extremes [5];
        int    n, rank, random_items;
        t_fill fill;
        bit    hold_done;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = kss_pkg::OP_APPEND;
        i_value      = '0;
        i_rank       = '0;
        random_items = 0;
        hold_done    = 0;
        extremes     = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1, 32'sh1};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty set, one element, extremes, equal keys, rank at count
        request_rank(0);
        send_item(kss_pkg::OP_APPEND, 32'sh7fff_ffff, t_rank'(RANK_MAX));
        request_rank(0);
        foreach (extremes[e])
            send_item(kss_pkg::OP_APPEND, extremes[e], t_rank'($urandom_range(0, RANK_MAX)));
        request_rank(4);
        foreach (extremes[e])
            send_item(kss_pkg::OP_APPEND, extremes[e], t_rank'($urandom_range(0, RANK_MAX)));
        request_rank(RANK_MAX);
        repeat (5)
            send_item(kss_pkg::OP_APPEND, -32'sd7, t_rank'($urandom_range(0, RANK_MAX)));
        request_rank(2);
        append_set(3, FILL_RANDOM);
        request_rank(3);

        while (random_items < RANDOM_ITEMS || selects_sent < MIN_SELECTS) begin
            if (!hold_done && random_items > 200) begin
                hold_req  = 1'b1;
                hold_done = 1;
            end
            if ($urandom_range(0, 11) == 0) begin
                request_rank($urandom_range(0, RANK_MAX));
                random_items++;
            end else begin
                n    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 16);
                fill = t_fill'($urandom_range(0, 3));
                append_set(n, fill);
                rank = ($urandom_range(0, 7) == 0) ? $urandom_range(n, RANK_MAX)
                                                   : $urandom_range(0, n - 1);
                request_rank(rank);
                random_items += n + 1;
            end
        end

        i_valid = 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
